// ===== design/i2da_pkg.sv =====
// Shared constants for the integer to decimal ASCII converter.
`default_nettype none
package i2da_pkg;
	localparam int unsigned VALUE_BITS_DEFAULT = 32;
	localparam int unsigned DIGIT_W            = 4;
	localparam int unsigned BITS_PER_STEP      = 4;
	localparam int unsigned CHAR_W             = 7;
	localparam logic [CHAR_W-1:0] CH_ZERO      = 7'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS     = 7'd45;
endpackage
`default_nettype wire

// ===== design/i2da_value_if.sv =====
// Stream interface that carries one signed integer per word.
`default_nettype none
interface i2da_value_if #(
	parameter int unsigned VALUE_BITS = i2da_pkg::VALUE_BITS_DEFAULT
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== design/i2da_char_if.sv =====
// Stream interface that carries one ASCII character per word.
`default_nettype none
interface i2da_char_if;
	logic                             valid;
	logic                             ready;
	logic [i2da_pkg::CHAR_W-1:0]      char_code;
	logic                             last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

// ===== design/i2da_dabble_stage.sv =====
// One pipeline stage of the shift-and-add-three binary to BCD conversion.
`default_nettype none
module i2da_dabble_stage #(
	parameter int unsigned NUM_DIGITS = 12,
	parameter int unsigned MAG_W      = 32,
	parameter int unsigned STEPS      = i2da_pkg::BITS_PER_STEP
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   up_valid,
	output      logic                                   up_ready,
	input  wire logic                                   up_neg,
	input  wire logic [NUM_DIGITS*i2da_pkg::DIGIT_W-1:0] up_bcd,
	input  wire logic [MAG_W-1:0]                       up_bin,
	output      logic                                   dn_valid,
	input  wire logic                                   dn_ready,
	output      logic                                   dn_neg,
	output      logic [NUM_DIGITS*i2da_pkg::DIGIT_W-1:0] dn_bcd,
	output      logic [MAG_W-1:0]                       dn_bin
);
	localparam int unsigned BCD_W = NUM_DIGITS * i2da_pkg::DIGIT_W;

	logic             valid_s1;
	logic             neg_s1;
	logic [BCD_W-1:0] bcd_s1;
	logic [MAG_W-1:0] bin_s1;
	logic [BCD_W-1:0] bcd_nxt;
	logic [MAG_W-1:0] bin_nxt;

	// Each step corrects every digit of five or more, then shifts one binary bit in.
	always_comb begin
		bcd_nxt = up_bcd;
		bin_nxt = up_bin;
		for (int s = 0; s < STEPS; s++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (bcd_nxt[d*i2da_pkg::DIGIT_W +: i2da_pkg::DIGIT_W] >= 4'd5) begin
					bcd_nxt[d*i2da_pkg::DIGIT_W +: i2da_pkg::DIGIT_W] =
						bcd_nxt[d*i2da_pkg::DIGIT_W +: i2da_pkg::DIGIT_W] + 4'd3;
				end
			end
			bcd_nxt = {bcd_nxt[BCD_W-2:0], bin_nxt[MAG_W-1]};
			bin_nxt = {bin_nxt[MAG_W-2:0], 1'b0};
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			neg_s1 <= up_neg;
			bcd_s1 <= bcd_nxt;
			bin_s1 <= bin_nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_neg   = neg_s1;
	assign dn_bcd   = bcd_s1;
	assign dn_bin   = bin_s1;
endmodule
`default_nettype wire

// ===== design/int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII text converter.
//
//   port      dir  words                     payload
//   numbers   in   one integer each          value (VALUE_BITS, signed)
//   chars     out  one character each        char_code (7), last
//
// Each integer produces 1 to 11 characters for 32 bits (minus sign plus up to
// ten digits); the serializer emits one character per cycle while chars is
// not stalled. The pipeline is a magnitude stage, one binary to BCD stage per
// four bits, a leading digit stage, the serializer and the output register.
// Reset clears only valid bits. A stall on chars holds the output word and
// backs up the pipeline.
`default_nettype none
module int_to_decimal_ascii #(
	parameter int unsigned VALUE_BITS = i2da_pkg::VALUE_BITS_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	i2da_value_if.sink         numbers,
	i2da_char_if.source        chars
);
	localparam int unsigned BPS     = i2da_pkg::BITS_PER_STEP;
	localparam int unsigned DW      = i2da_pkg::DIGIT_W;
	localparam int unsigned NSTEP   = (VALUE_BITS + BPS - 1) / BPS;
	localparam int unsigned MAG_W   = NSTEP * BPS;
	localparam int unsigned ND      = (VALUE_BITS * 3) / 10 + 2;
	localparam int unsigned BCD_W   = ND * DW;
	localparam int unsigned IDX_W   = $clog2(ND);

	// Magnitude stage.
	logic                  valid_s1;
	logic                  neg_s1;
	logic [MAG_W-1:0]      mag_s1;
	logic                  ready_s1;
	logic [VALUE_BITS-1:0] raw;
	logic                  raw_neg;
	logic [VALUE_BITS-1:0] raw_mag;

	// Dabble chain, index 0 is the magnitude stage output.
	logic                  chain_valid [NSTEP+1];
	logic                  chain_ready [NSTEP+1];
	logic                  chain_neg   [NSTEP+1];
	logic [BCD_W-1:0]      chain_bcd   [NSTEP+1];
	logic [MAG_W-1:0]      chain_bin   [NSTEP+1];

	// Leading digit stage.
	logic                  valid_s2;
	logic                  neg_s2;
	logic [ND-1:0][DW-1:0] dig_s2;
	logic [IDX_W-1:0]      lead_s2;
	logic                  ready_s2;
	logic [IDX_W-1:0]      lead_nxt;

	// Serializer and output register.
	logic                  ser_valid_q;
	logic                  ser_neg_q;
	logic [ND-1:0][DW-1:0] ser_dig_q;
	logic [IDX_W-1:0]      ser_idx_q;
	logic                  out_valid_q;
	logic [i2da_pkg::CHAR_W-1:0] out_char_q;
	logic                  out_last_q;
	logic                  out_take;
	logic                  emit;
	logic                  ser_done;
	logic                  ser_load;
	logic [DW-1:0]         cur_digit;
	logic [i2da_pkg::CHAR_W-1:0] cur_char;
	logic                  cur_last;

	assign raw     = numbers.value;
	assign raw_neg = raw[VALUE_BITS-1];
	// The most negative value maps to its unsigned magnitude without overflow.
	assign raw_mag = raw_neg ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

	assign ready_s1      = !valid_s1 || chain_ready[0];
	assign numbers.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= numbers.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && numbers.valid) begin
			neg_s1 <= raw_neg;
			mag_s1 <= MAG_W'(raw_mag);
		end
	end

	assign chain_valid[0] = valid_s1;
	assign chain_neg[0]   = neg_s1;
	assign chain_bcd[0]   = '0;
	assign chain_bin[0]   = mag_s1;

	for (genvar g = 0; g < NSTEP; g++) begin : g_dabble
		i2da_dabble_stage #(
			.NUM_DIGITS (ND),
			.MAG_W      (MAG_W),
			.STEPS      (BPS)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[g]),
			.up_ready (chain_ready[g]),
			.up_neg   (chain_neg[g]),
			.up_bcd   (chain_bcd[g]),
			.up_bin   (chain_bin[g]),
			.dn_valid (chain_valid[g+1]),
			.dn_ready (chain_ready[g+1]),
			.dn_neg   (chain_neg[g+1]),
			.dn_bcd   (chain_bcd[g+1]),
			.dn_bin   (chain_bin[g+1])
		);
	end

	assign chain_ready[NSTEP] = ready_s2;

	// Highest nonzero digit; zero keeps index 0 so it prints a single '0'.
	always_comb begin
		lead_nxt = '0;
		for (int k = 0; k < ND; k++) begin
			if (chain_bcd[NSTEP][k*DW +: DW] != '0) begin
				lead_nxt = IDX_W'(k);
			end
		end
	end

	assign ready_s2 = !valid_s2 || ser_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= chain_valid[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && chain_valid[NSTEP]) begin
			neg_s2  <= chain_neg[NSTEP];
			dig_s2  <= chain_bcd[NSTEP];
			lead_s2 <= lead_nxt;
		end
	end

	assign out_take  = !out_valid_q || chars.ready;
	assign emit      = ser_valid_q && out_take;
	assign cur_last  = !ser_neg_q && (ser_idx_q == '0);
	assign ser_done  = emit && cur_last;
	assign ser_load  = valid_s2 && (!ser_valid_q || ser_done);
	assign cur_digit = ser_dig_q[ser_idx_q];
	assign cur_char  = ser_neg_q ? i2da_pkg::CH_MINUS
	                             : i2da_pkg::CH_ZERO + i2da_pkg::CHAR_W'(cur_digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ser_load) begin
				ser_valid_q <= 1'b1;
			end else if (ser_done) begin
				ser_valid_q <= 1'b0;
			end
			if (out_take) begin
				out_valid_q <= ser_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			ser_neg_q <= neg_s2;
			ser_dig_q <= dig_s2;
			ser_idx_q <= lead_s2;
		end else if (emit) begin
			if (ser_neg_q) begin
				ser_neg_q <= 1'b0;
			end else begin
				ser_idx_q <= ser_idx_q - 1'b1;
			end
		end
		if (emit) begin
			out_char_q <= cur_char;
			out_last_q <= cur_last;
		end
	end

	assign chars.valid     = out_valid_q;
	assign chars.char_code = out_char_q;
	assign chars.last      = out_last_q;

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_char_q == i2da_pkg::CH_MINUS) |-> !out_last_q)
		else $error("minus sign flagged as last character");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_valid_q |-> (32'(ser_idx_q) < ND))
		else $error("serializer digit index out of range");

	a_lead_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ser_load && (lead_s2 != '0) |=> (ser_dig_q[ser_idx_q] != '0))
		else $error("leading digit of a multi-digit number is zero");

	a_done_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ser_done && !valid_s2 |=> !ser_valid_q)
		else $error("serializer kept a word after its last character");
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the integer to decimal ASCII converter.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NUM_BITS      = 32;
	localparam int unsigned DECIMAL_BASE  = 10;
	localparam int unsigned RANDOM_COUNT  = 100;
	localparam int unsigned RESET_CYCLES  = 8;
	localparam int unsigned DRAIN_CYCLES  = 2 * (NUM_BITS / 4 + 3) + 8;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned HOLD_AFTER    = 200;

	typedef struct packed {
		logic [i2da_pkg::CHAR_W-1:0] char_code;
		logic                        last;
	} char_word_t;

	// Predicts the character sequence of each accepted number and checks
	// the characters that leave the block against it in order.
	class decimal_text_scoreboard;
		char_word_t pending_chars[$];
		int unsigned failures;

		function void add_number(logic signed [NUM_BITS-1:0] number);
			bit [NUM_BITS-1:0] magnitude;
			bit [3:0]          digits[$];
			char_word_t        word;
			magnitude = number;
			// Negating the raw bits keeps the most negative value exact.
			if (number[NUM_BITS-1]) begin
				magnitude = ~magnitude + 1'b1;
				word.char_code = i2da_pkg::CH_MINUS;
				word.last = 1'b0;
				pending_chars.push_back(word);
			end
			do begin
				digits.push_front(4'(magnitude % DECIMAL_BASE));
				magnitude = magnitude / DECIMAL_BASE;
			end while (magnitude != 0);
			foreach (digits[i]) begin
				word.char_code = i2da_pkg::CH_ZERO + digits[i];
				word.last = (i == digits.size() - 1);
				pending_chars.push_back(word);
			end
		endfunction

		function void report(string what);
			failures++;
			$display("%0t: %s", $time, what);
		endfunction

		function void check_char(logic [i2da_pkg::CHAR_W-1:0] char_code, logic last);
			char_word_t want;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected char_code %0d last %0d", char_code, last));
				return;
			end
			want = pending_chars.pop_front();
			if (char_code !== want.char_code)
				report($sformatf("char_code expected %0d actual %0d",
					want.char_code, char_code));
			if (last !== want.last)
				report($sformatf("last expected %0d actual %0d", want.last, last));
		endfunction

		function int unsigned pending();
			return pending_chars.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	i2da_value_if #(.VALUE_BITS(NUM_BITS)) numbers_if ();
	i2da_char_if chars_if ();

	int_to_decimal_ascii #(
		.VALUE_BITS(NUM_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.numbers(numbers_if.sink),
		.chars  (chars_if.source)
	);

	decimal_text_scoreboard board = new();

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [NUM_BITS-1:0] pick_number();
		logic [NUM_BITS-1:0] bits;
		logic [NUM_BITS-1:0] decade;
		int unsigned         steps;
		bits = $urandom;
		case ($urandom_range(0, 3))
			0: ;
			1: begin
				// Short magnitudes give short strings and expose the leading digit logic.
				bits = bits >> $urandom_range(0, NUM_BITS - 1);
				if ($urandom_range(0, 1))
					bits = ~bits + 1'b1;
			end
			2: begin
				decade = 1;
				steps = $urandom_range(0, 9);
				repeat (steps) decade = decade * DECIMAL_BASE;
				bits = decade + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1))
					bits = ~bits + 1'b1;
			end
			default: begin
				if ($urandom_range(0, 1))
					bits = {1'b0, {(NUM_BITS-1){1'b1}}} - $urandom_range(0, 3);
				else
					bits = {1'b1, {(NUM_BITS-1){1'b0}}} + $urandom_range(0, 3);
			end
		endcase
		return bits;
	endfunction

	// Offers one word, after an idle gap if gap is nonzero, and returns once it is accepted.
	task automatic send_number(logic signed [NUM_BITS-1:0] number, int unsigned gap);
		if (gap > 0) begin
			numbers_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		numbers_if.valid <= 1'b1;
		numbers_if.value <= number;
		do @(posedge clk); while (!numbers_if.ready);
		board.add_number(number);
	endtask

	// Character receiver with random stalls and one long hold-off.
	initial begin : char_receiver
		int unsigned hold_left;
		int unsigned chars_seen;
		int unsigned cycle;
		int unsigned gap;
		bit          long_done;
		hold_left = 0;
		chars_seen = 0;
		cycle = 0;
		long_done = 1'b0;
		chars_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			cycle++;
			if (chars_if.valid && chars_if.ready) begin
				board.check_char(chars_if.char_code, chars_if.last);
				chars_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				chars_if.ready <= 1'b0;
			end else if (!long_done && chars_seen >= HOLD_AFTER) begin
				long_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				chars_if.ready <= 1'b0;
			end else if ((cycle / 128) % 4 == 0) begin
				chars_if.ready <= 1'b1;
			end else begin
				gap = pick_gap();
				if (gap == 0) begin
					chars_if.ready <= 1'b1;
				end else begin
					hold_left = gap - 1;
					chars_if.ready <= 1'b0;
				end
			end
		end
	end

	initial begin : number_sender
		logic signed [NUM_BITS-1:0] directed[$];
		int unsigned gap;
		directed = '{
			32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
			-32'sd7, 32'sd2147483647, 32'sh80000000, -32'sd2147483647,
			32'sd1000000000, -32'sd1000000000, 32'sd999999999, -32'sd999999999,
			32'sd123456789, 32'sh55555555, 32'shAAAAAAAA, 32'sd0
		};
		arst_n = 1'b0;
		numbers_if.valid = 1'b0;
		numbers_if.value = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_number(directed[i], (i % 4 == 3) ? pick_gap() : 0);
		for (int unsigned n = 0; n < RANDOM_COUNT; n++) begin
			// Every fourth stretch of items is sent back to back.
			gap = (n % 32 < 8) ? 0 : pick_gap();
			send_number(pick_number(), gap);
		end
		numbers_if.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.pending() != 0)
			board.report($sformatf("%0d characters never arrived", board.pending()));
		if (board.failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== sim.f =====
design/i2da_pkg.sv
design/i2da_value_if.sv
design/i2da_char_if.sv
design/i2da_dabble_stage.sv
design/int_to_decimal_ascii.sv
verif/testbench.sv
